[design/ufpc_pkg.sv]
// Shared types, character constants and hex helpers for the percent codec.
`timescale 1ns / 1ps

package ufpc_pkg;

	localparam logic [7:0] CHAR_PCT    = 8'h25;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TILDE  = 8'h7E;
	localparam logic [7:0] CHAR_DASH   = 8'h2D;
	localparam logic [7:0] CHAR_UNDER  = 8'h5F;
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_0      = 8'h30;
	localparam logic [7:0] CHAR_9      = 8'h39;
	localparam logic [7:0] CHAR_UA     = 8'h41;
	localparam logic [7:0] CHAR_UF     = 8'h46;
	localparam logic [7:0] CHAR_UZ     = 8'h5A;
	localparam logic [7:0] CHAR_LA     = 8'h61;
	localparam logic [7:0] CHAR_LF     = 8'h66;
	localparam logic [7:0] CHAR_LZ     = 8'h7A;
	localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
	localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;
	localparam logic [4:0] HEX_NONE      = 5'd16;

	// One unit of work handed from the classifier to the emitter.
	// esc = 1: three results '%', hi digit, lo digit of data.
	// esc = 0: one result built from the remaining fields.
	typedef struct packed {
		logic       esc;
		logic [7:0] data;
		logic       has_byte;
		logic       string_end;
		logic       bad;
	} job_t;

	localparam int JOB_W = $bits(job_t);

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] v;
		v = {4'd0, nib};
		return (nib > 4'd9) ? v + HEX_ALPHA_OFS : v + HEX_DIGIT_OFS;
	endfunction

	// Returns HEX_NONE when c is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			d = c - CHAR_0;
			return d[4:0];
		end
		if (c >= CHAR_UA && c <= CHAR_UF) begin
			d = c - CHAR_UA + 8'd10;
			return d[4:0];
		end
		if (c >= CHAR_LA && c <= CHAR_LF) begin
			d = c - CHAR_LA + 8'd10;
			return d[4:0];
		end
		return HEX_NONE;
	endfunction

	function automatic logic unreserved(input logic [7:0] c);
		return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ) ||
			(c >= CHAR_LA && c <= CHAR_LZ) || c == CHAR_DASH || c == CHAR_UNDER ||
			c == CHAR_DOT || c == CHAR_TILDE;
	endfunction

endpackage

[design/ufpc_if.sv]
// Channel interfaces: input bytes, results, and the mode register write port.
`timescale 1ns / 1ps

interface ufpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ufpc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       run_last;
	logic       string_end;
	logic       bad_escape;
	modport source (output valid, output out_byte, output has_byte, output run_last,
		output string_end, output bad_escape, input ready);
	modport sink   (input valid, input out_byte, input has_byte, input run_last,
		input string_end, input bad_escape, output ready);
endinterface

interface ufpc_cfg_if;
	logic valid;
	logic ready;
	logic decode_mode;
	modport source (output valid, output decode_mode, input ready);
	modport sink   (input valid, input decode_mode, output ready);
endinterface

[design/ufpc_front.sv]
// Classifier: holds mode and escape state, turns input bytes into jobs.
`timescale 1ns / 1ps

module ufpc_front
	import ufpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       cfg_fire,
	input  logic       cfg_mode,
	output logic       push,
	output job_t       job
);

	typedef enum logic [2:0] {
		ESC_IDLE = 3'b001,
		ESC_HI   = 3'b010,
		ESC_LO   = 3'b100
	} esc_state_t;

	logic       mode_q;
	esc_state_t esc_q, esc_d;
	logic [3:0] nib_q, nib_d;
	logic       produce;
	logic [4:0] hv;

	assign hv = hex_value(in_byte);

	always_comb begin
		produce = 1'b1;
		job = '{esc: 1'b0, data: in_byte, has_byte: 1'b1, string_end: in_last, bad: 1'b0};
		esc_d = ESC_IDLE;
		nib_d = nib_q;
		if (!mode_q) begin
			if (unreserved(in_byte)) begin
				job.data = in_byte;
			end else if (in_byte == CHAR_SPACE) begin
				job.data = CHAR_PLUS;
			end else begin
				job.esc = 1'b1;
			end
		end else begin
			case (esc_q)
				ESC_HI: begin
					if (hv[4]) begin
						job = '{esc: 1'b0, data: 8'd0, has_byte: 1'b0,
							string_end: in_last, bad: 1'b1};
					end else begin
						nib_d = hv[3:0];
						esc_d = ESC_LO;
						produce = in_last;
						job = '{esc: 1'b0, data: 8'd0, has_byte: 1'b0,
							string_end: 1'b1, bad: 1'b1};
					end
				end
				ESC_LO: begin
					if (hv[4]) begin
						job = '{esc: 1'b0, data: 8'd0, has_byte: 1'b0,
							string_end: in_last, bad: 1'b1};
					end else begin
						job.data = {nib_q, hv[3:0]};
					end
				end
				default: begin
					if (in_byte == CHAR_PLUS) begin
						job.data = CHAR_SPACE;
					end else if (in_byte == CHAR_PCT) begin
						esc_d = ESC_HI;
						produce = in_last;
						job = '{esc: 1'b0, data: 8'd0, has_byte: 1'b0,
							string_end: 1'b1, bad: 1'b1};
					end
				end
			endcase
		end
		if (in_last) begin
			esc_d = ESC_IDLE;
			nib_d = 4'd0;
		end
	end

	assign push = in_fire & produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			esc_q  <= ESC_IDLE;
			nib_q  <= 4'd0;
		end else if (cfg_fire) begin
			mode_q <= cfg_mode;
			esc_q  <= ESC_IDLE;
			nib_q  <= 4'd0;
		end else if (in_fire) begin
			esc_q <= esc_d;
			nib_q <= nib_d;
		end
	end

endmodule

[design/ufpc_queue.sv]
// Small job FIFO between the classifier and the emitter.
`timescale 1ns / 1ps

module ufpc_queue
	import ufpc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head  = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

[design/ufpc_back.sv]
// Emitter: expands the head job into results and holds them in an output register.
`timescale 1ns / 1ps

module ufpc_back
	import ufpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       empty,
	output logic       pop,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_last,
	output logic       string_end,
	output logic       bad_escape
);

	localparam logic [1:0] STEP_PCT = 2'd0;
	localparam logic [1:0] STEP_HI  = 2'd1;
	localparam logic [1:0] STEP_LO  = 2'd2;

	logic [1:0] step_q;
	logic       load;
	logic       final_res;
	logic [7:0] nxt_byte;

	always_comb begin
		final_res = 1'b1;
		nxt_byte  = head.data;
		if (head.esc) begin
			case (step_q)
				STEP_PCT: begin
					nxt_byte  = CHAR_PCT;
					final_res = 1'b0;
				end
				STEP_HI: begin
					nxt_byte  = hex_digit(head.data[7:4]);
					final_res = 1'b0;
				end
				default: nxt_byte = hex_digit(head.data[3:0]);
			endcase
		end
	end

	assign load = !empty && (!out_valid || out_ready);
	assign pop  = load && final_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			step_q    <= STEP_PCT;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				step_q    <= final_res ? STEP_PCT :
					(step_q == STEP_PCT ? STEP_HI : STEP_LO);
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte   <= nxt_byte;
			has_byte   <= head.has_byte;
			run_last   <= final_res;
			string_end <= final_res & head.string_end;
			bad_escape <= head.bad;
		end
	end

endmodule

[design/url_form_percent_codec.sv]
// A result passes through the job queue and then the output register before it is valid.
// Throughput: one input per cycle for one-result bytes while the output does not stall;
//   an encoded escape makes three results on the single output port, so input can be held off.
// A job queue of QUEUE_DEPTH entries lets input and output stall independently.
// Reset (arst_n low, async): encode mode, no escape pending, queue and output empty.
`timescale 1ns / 1ps

module url_form_percent_codec
	import ufpc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	ufpc_in_if.sink   in_ch,
	ufpc_out_if.source out_ch,
	ufpc_cfg_if.sink  cfg
);

	// Front/queue handshake
	job_t job, head;
	logic push, pop, q_empty, q_full;
	logic in_fire, cfg_fire;

	// Input is taken whenever the queue has room; a byte that leaves an
	// escape pending pushes nothing but is still consumed.
	assign in_ch.ready = !q_full;
	assign in_fire     = in_ch.valid & in_ch.ready;

	// Mode register is always writable; the user must write only while idle, the block does not enforce it.
	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid;

	ufpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_byte   (in_ch.in_byte),
		.in_last   (in_ch.in_last),
		.cfg_fire  (cfg_fire),
		.cfg_mode  (cfg.decode_mode),
		.push      (push),
		.job       (job)
	);

	ufpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (job),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back end walks the head job one result per cycle, while the output is not stalled, into the output register.
	ufpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (q_empty),
		.pop        (pop),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_byte   (out_ch.out_byte),
		.has_byte   (out_ch.has_byte),
		.run_last   (out_ch.run_last),
		.string_end (out_ch.string_end),
		.bad_escape (out_ch.bad_escape)
	);

endmodule

[bench/url_form_percent_codec_tb.sv]
// Self-checking testbench for the byte-serial form-urlencoded percent codec.
`timescale 1ns / 1ps

module url_form_percent_codec_tb;
	import ufpc_pkg::*;

	// decode_mode register values
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// Share of cycles in which each side holds off, in percent.
	localparam int IDLE_PCT = 25;
	// Quiet cycles after the last expected result: enough for a full job queue and
	// the output register, with margin.
	localparam int DRAIN_CYCLES = 10;

	// Where the decoder stands inside a %XX escape.
	typedef enum logic [1:0] {
		ESC_IDLE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HI   = 2'd2
	} esc_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} feed_item_t;

	// One converted output transaction, field for field as on the port.
	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       run_last;
		logic       str_end;
		logic       bad;
	} coded_t;

	logic clk = 1'b0;
	logic arst_n;

	ufpc_in_if  in_ch();
	ufpc_out_if out_ch();
	ufpc_cfg_if cfg();

	url_form_percent_codec uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes still to be offered, and converted bytes still owed by the block.
	feed_item_t  feed_q[$];
	coded_t      codec_results_q[$];

	// Predictor copy of the codec state.
	logic        dec_mode;
	esc_phase_t  esc_phase;
	logic [3:0]  hi_nib;

	int unsigned in_sent;    // bytes put on the input channel
	int unsigned in_taken;   // input transactions seen at a rising edge
	int          fed_items;  // bytes queued so far, drives phase lengths
	int          errors;
	logic        steady;     // when set, neither side holds off

	task automatic report_fault(input string msg);
		errors++;
		if (errors <= 100)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	// Hex digit value of an ASCII byte, HEX_NONE if it is not a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		v = HEX_NONE;
		if (c >= CHAR_0 && c <= CHAR_9)
			v = {1'b0, c[3:0]};
		else if ((c >= CHAR_UA && c <= CHAR_UF) || (c >= CHAR_LA && c <= CHAR_LF))
			v = {1'b0, c[3:0]} + 5'd9;    // 'A'/'a' have low nibble 1
		return v;
	endfunction

	// Uppercase ASCII hex digit of a nibble, as the encoder emits it.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? CHAR_0 + {4'd0, nib} : CHAR_UA + {4'd0, nib} - 8'd10;
	endfunction

	// Letters, digits and - _ . ~ pass the encoder untouched.
	function automatic logic is_plain(input logic [7:0] c);
		logic ok;
		ok = (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ);
		ok = ok || (c >= CHAR_LA && c <= CHAR_LZ);
		return ok || c == CHAR_DASH || c == CHAR_UNDER || c == CHAR_DOT || c == CHAR_TILDE;
	endfunction

	task automatic add_result(input logic [7:0] d, input logic has, input logic rl,
		input logic se, input logic bad);
		coded_t r;
		r.data     = d;
		r.has      = has;
		r.run_last = rl;
		r.str_end  = se;
		r.bad      = bad;
		codec_results_q.push_back(r);
	endtask

	// Works out the results that one accepted input byte causes.
	task automatic codec_step(input logic [7:0] c, input logic last);
		logic [4:0] v;
		v = hex_val(c);
		if (dec_mode == MODE_ENCODE) begin
			if (is_plain(c)) begin
				add_result(c, 1'b1, 1'b1, last, 1'b0);
			end else if (c == CHAR_SPACE) begin
				add_result(CHAR_PLUS, 1'b1, 1'b1, last, 1'b0);
			end else begin
				add_result(CHAR_PCT, 1'b1, 1'b0, 1'b0, 1'b0);
				add_result(hex_char(c[7:4]), 1'b1, 1'b0, 1'b0, 1'b0);
				add_result(hex_char(c[3:0]), 1'b1, 1'b1, last, 1'b0);
			end
			esc_phase = ESC_IDLE;
		end else if (esc_phase == ESC_PCT || esc_phase == ESC_HI) begin
			if (v == HEX_NONE) begin
				// escape and the offending byte are dropped, status only
				add_result(8'h00, 1'b0, 1'b1, last, 1'b1);
				esc_phase = ESC_IDLE;
			end else if (esc_phase == ESC_PCT) begin
				hi_nib    = v[3:0];
				esc_phase = ESC_HI;
				if (last)
					add_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);    // cut off after first digit
			end else begin
				add_result({hi_nib, v[3:0]}, 1'b1, 1'b1, last, 1'b0);
				esc_phase = ESC_IDLE;
			end
		end else if (c == CHAR_PLUS) begin
			add_result(CHAR_SPACE, 1'b1, 1'b1, last, 1'b0);
		end else if (c == CHAR_PCT) begin
			esc_phase = ESC_PCT;
			if (last)
				add_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);    // cut off right after '%'
		end else begin
			add_result(c, 1'b1, 1'b1, last, 1'b0);
		end
		if (last) begin
			esc_phase = ESC_IDLE;
			hi_nib    = 4'd0;
		end
	endtask

	// Input driver: changes at the falling edge. valid stays up until the
	// monitor has counted the transaction, then the next byte may follow
	// after a random hold-off.
	always @(negedge clk) begin : in_driver
		logic       nxt_valid;
		logic [7:0] nxt_byte;
		logic       nxt_last;
		feed_item_t item;
		nxt_valid = in_ch.valid;
		nxt_byte  = in_ch.in_byte;
		nxt_last  = in_ch.in_last;
		if (nxt_valid && in_sent == in_taken)
			nxt_valid = 1'b0;
		if (!nxt_valid && feed_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
			item      = feed_q.pop_front();
			nxt_valid = 1'b1;
			nxt_byte  = item.data;
			nxt_last  = item.last;
			in_sent++;
		end
		in_ch.valid   <= nxt_valid;
		in_ch.in_byte <= nxt_byte;
		in_ch.in_last <= nxt_last;
	end

	// Output back-pressure, also moved at the falling edge.
	always @(negedge clk)
		out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

	// Monitor: predicts on every input transaction and checks every output
	// transaction against the oldest prediction. Prediction runs first so a
	// same-cycle result would still find its entry.
	always @(posedge clk) begin : monitor
		coded_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				codec_step(in_ch.in_byte, in_ch.in_last);
				in_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (codec_results_q.size() == 0) begin
					report_fault($sformatf("result %02h with nothing pending", out_ch.out_byte));
				end else begin
					want = codec_results_q.pop_front();
					if (out_ch.out_byte !== want.data)
						report_fault($sformatf("out_byte %02h, want %02h",
							out_ch.out_byte, want.data));
					if (out_ch.has_byte !== want.has)
						report_fault($sformatf("has_byte %b, want %b (byte %02h)",
							out_ch.has_byte, want.has, want.data));
					if (out_ch.run_last !== want.run_last)
						report_fault($sformatf("run_last %b, want %b (byte %02h)",
							out_ch.run_last, want.run_last, want.data));
					if (out_ch.string_end !== want.str_end)
						report_fault($sformatf("string_end %b, want %b (byte %02h)",
							out_ch.string_end, want.str_end, want.data));
					if (out_ch.bad_escape !== want.bad)
						report_fault($sformatf("bad_escape %b, want %b (byte %02h)",
							out_ch.bad_escape, want.bad, want.data));
				end
			end
		end
	end

	task automatic feed(input logic [7:0] b, input logic last);
		feed_item_t item;
		item.data = b;
		item.last = last;
		feed_q.push_back(item);
		fed_items++;
	endtask

	// Queues a whole string, flagging its final byte.
	task automatic feed_str(input string s);
		for (int i = 0; i < s.len(); i++)
			feed(s[i], i == s.len() - 1);
	endtask

	// Waits until every byte went in and every result came out, then lets
	// the block settle: a pending escape produces nothing to wait on.
	task automatic wait_drained();
		while (feed_q.size() != 0 || in_sent != in_taken || codec_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mode write; only called with the block idle. Any write clears the
	// escape state.
	task automatic write_mode(input logic m);
		@(negedge clk);
		cfg.valid       <= 1'b1;
		cfg.decode_mode <= m;
		do
			@(posedge clk);
		while (!cfg.ready);
		dec_mode  = m;
		esc_phase = ESC_IDLE;
		hi_nib    = 4'd0;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_hex_char(input logic [3:0] nib);
		if (nib < 4'd10)
			return CHAR_0 + {4'd0, nib};
		return ($urandom_range(1) ? CHAR_LA : CHAR_UA) + {4'd0, nib} - 8'd10;
	endfunction

	function automatic logic [7:0] rand_non_hex();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		while (hex_val(b) != HEX_NONE)
			b = 8'($urandom_range(255));
		return b;
	endfunction

	// Mostly well-formed escapes and '+', some plain bytes, some broken or
	// cut-off escapes and raw noise.
	task automatic queue_decode_string();
		logic [7:0] s[$];
		logic [7:0] b;
		int         r;
		repeat ($urandom_range(1, 5)) begin
			r = $urandom_range(99);
			if (r < 45) begin
				s.push_back(CHAR_PCT);
				s.push_back(rand_hex_char(4'($urandom_range(15))));
				s.push_back(rand_hex_char(4'($urandom_range(15))));
			end else if (r < 60) begin
				s.push_back(CHAR_PLUS);
			end else if (r < 78) begin
				b = 8'($urandom_range(255));
				while (b == CHAR_PCT)
					b = 8'($urandom_range(255));
				s.push_back(b);
			end else if (r < 88) begin
				s.push_back(CHAR_PCT);
				if ($urandom_range(1))
					s.push_back(rand_hex_char(4'($urandom_range(15))));
				s.push_back(rand_non_hex());
			end else begin
				s.push_back(8'($urandom_range(255)));
			end
		end
		// now and then the string stops inside an escape
		if ($urandom_range(9) == 0) begin
			s.push_back(CHAR_PCT);
			if ($urandom_range(1))
				s.push_back(rand_hex_char(4'($urandom_range(15))));
		end
		foreach (s[i])
			feed(s[i], i == s.size() - 1);
	endtask

	task automatic queue_encode_string();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			feed(($urandom_range(99) < 80) ? 8'($urandom_range(255)) : CHAR_SPACE,
				i == n - 1);
	endtask

	task automatic run_random(input logic m, input int target, input logic no_gaps);
		int start;
		write_mode(m);
		steady = no_gaps;
		start  = fed_items;
		while (fed_items - start < target) begin
			if (m == MODE_DECODE)
				queue_decode_string();
			else
				queue_encode_string();
		end
		wait_drained();
		steady = 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.in_byte   = 8'h00;
		in_ch.in_last   = 1'b0;
		out_ch.ready    = 1'b0;
		cfg.valid       = 1'b0;
		cfg.decode_mode = MODE_ENCODE;
		dec_mode        = MODE_ENCODE;
		esc_phase       = ESC_IDLE;
		hi_nib          = 4'd0;
		in_sent         = 0;
		in_taken        = 0;
		fed_items       = 0;
		errors          = 0;
		steady          = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Encode: byte extremes, space, a digit, letters, '-' and '~', then '%' and '+'
		// which must themselves be escaped.
		write_mode(MODE_ENCODE);
		feed(8'h00, 1'b0);
		feed(8'hFF, 1'b0);
		feed(CHAR_SPACE, 1'b0);
		feed_str("-~9Za%");
		feed(CHAR_PLUS, 1'b1);
		wait_drained();

		// Decode: '+', plain byte, upper and lower case escapes, bad first
		// digit, bad second digit on the last byte, then strings cut off
		// right after '%' and after the first digit.
		write_mode(MODE_DECODE);
		feed_str("+q%41%fF%G%4z");
		feed_str("%");
		feed_str("%4");
		wait_drained();

		// A mode write in the middle of an escape drops it: "41" then
		// passes through as two plain bytes.
		feed(CHAR_PCT, 1'b0);
		wait_drained();
		write_mode(MODE_DECODE);
		feed_str("41");
		wait_drained();

		// Random strings; the first decode phase is the long stretch with
		// no hold-off on either side.
		run_random(MODE_ENCODE, 40, 1'b0);
		run_random(MODE_DECODE, 50, 1'b1);
		run_random(MODE_ENCODE, 40, 1'b0);
		run_random(MODE_DECODE, 50, 1'b0);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Hard stop, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
